FILE: design/wced_pkg.sv
package wced_pkg;

	// field widths
	localparam int WEIGHT_WIDTH = 24;
	localparam int WIDE_W       = WEIGHT_WIDTH + 24;
	localparam int THR_W        = 23;
	localparam int TIME_W       = 32;
	localparam int AMOUNT_W     = 24;
	localparam int DUR_W        = 23;
	localparam int MODE_W       = 2;
	localparam int ECHO_W       = 24;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 2'd2;

	// configuration reset values
	localparam logic [THR_W-1:0]  THRESHOLD_RST = 23'd500;
	localparam logic [TIME_W-1:0] TIMEOUT_RST   = 32'd30000;
	localparam logic [TIME_W-1:0] COOLDOWN_RST  = 32'd5000;

	// saturation limit of the consumed amount
	localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = {AMOUNT_W{1'b1}};

	// divide by 1000 as multiply by ceil(2^38 / 1000) and shift, exact for 32-bit values
	localparam int                DIV_MUL_W = 29;
	localparam logic [DIV_MUL_W-1:0] DIV_MUL = 29'd274877907;
	localparam int                DIV_SHIFT = 38;
	localparam int                PROD_W    = TIME_W + DIV_MUL_W;

	// stage one transaction handed to the divide stage
	typedef struct packed {
		logic                valid;
		logic                event_valid;
		logic [AMOUNT_W-1:0] amount;
		logic [TIME_W-1:0]   elapsed;
		logic [MODE_W-1:0]   mode;
		logic [ECHO_W-1:0]   weight;
	} stage_t;

endpackage

FILE: design/wced_track.sv
module wced_track import wced_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [WEIGHT_WIDTH-1:0] weight_sample,
	input  logic [TIME_W-1:0]             time_ms,
	input  logic                          s2_ready,
	output stage_t                        s1
);

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE     = 2'd0,
		MODE_EVENT    = 2'd1,
		MODE_COOLDOWN = 2'd2
	} mode_t;

	logic [THR_W-1:0]               thr_q;
	logic [TIME_W-1:0]              timeout_q;
	logic [TIME_W-1:0]              cooldown_q;
	mode_t                          mode_q;
	mode_t                          mode_n;
	logic signed [WEIGHT_WIDTH-1:0] prev_q;
	logic signed [WEIGHT_WIDTH-1:0] before_q;
	logic [TIME_W-1:0]              start_q;
	logic [TIME_W-1:0]              last_q;
	stage_t                         s1_s1;

	logic                           accept;
	logic signed [WIDE_W-1:0]       cur_w;
	logic signed [WIDE_W-1:0]       prev_w;
	logic signed [WIDE_W-1:0]       before_w;
	logic signed [WIDE_W-1:0]       diff;
	logic [WIDE_W-1:0]              mag;
	logic [WIDE_W-1:0]              thr_w;
	logic signed [WIDE_W-1:0]       amt_diff;
	logic [AMOUNT_W-1:0]            amount;
	logic [TIME_W-1:0]              since_change;
	logic [TIME_W-1:0]              elapsed;
	logic                           ev_end;
	logic                           upd_last;
	logic                           start_ev;

	// handshake: stage one frees up whenever the divide stage takes its transaction
	assign in_ready = !s1_s1.valid || s2_ready;
	assign accept   = in_valid && in_ready;
	assign s1       = s1_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= THRESHOLD_RST;
			timeout_q  <= TIMEOUT_RST;
			cooldown_q <= COOLDOWN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q      <= cfg_wdata[THR_W-1:0];
				REG_TIMEOUT:   timeout_q  <= cfg_wdata[TIME_W-1:0];
				REG_COOLDOWN:  cooldown_q <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// jump size against the previous sample
	assign cur_w    = WIDE_W'(weight_sample);
	assign prev_w   = WIDE_W'(prev_q);
	assign before_w = WIDE_W'(before_q);
	assign diff     = cur_w - prev_w;
	assign mag      = diff[WIDE_W-1] ? WIDE_W'(-diff) : WIDE_W'(diff);
	assign thr_w    = WIDE_W'(thr_q);

	// wrapped time differences
	assign since_change = time_ms - last_q;
	assign elapsed      = time_ms - start_q;

	// consumed amount, clamped at zero and saturated
	assign amt_diff = before_w - cur_w;
	always_comb begin
		if (amt_diff[WIDE_W-1]) begin
			amount = '0;
		end else if (amt_diff > signed'(WIDE_W'(AMOUNT_MAX))) begin
			amount = AMOUNT_MAX;
		end else begin
			amount = amt_diff[AMOUNT_W-1:0];
		end
	end

	// mode transitions
	always_comb begin
		mode_n   = mode_q;
		ev_end   = 1'b0;
		upd_last = 1'b0;
		start_ev = 1'b0;
		case (mode_q)
			MODE_EVENT: begin
				if (mag < thr_w) begin
					if (since_change > timeout_q) begin
						ev_end   = 1'b1;
						mode_n   = MODE_COOLDOWN;
						upd_last = 1'b1;
					end
				end else begin
					upd_last = 1'b1;
				end
			end
			MODE_COOLDOWN: begin
				if (since_change > cooldown_q) begin
					mode_n = MODE_IDLE;
				end
			end
			default: begin
				mode_n = MODE_IDLE;
				if (mag > thr_w) begin
					mode_n   = MODE_EVENT;
					start_ev = 1'b1;
					upd_last = 1'b1;
				end
			end
		endcase
	end

	// mode, previous sample and stage one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			prev_q <= '0;
			s1_s1  <= '0;
		end else begin
			if (in_ready) begin
				s1_s1.valid <= accept;
			end
			if (accept) begin
				mode_q            <= mode_n;
				prev_q            <= weight_sample;
				s1_s1.event_valid <= ev_end;
				s1_s1.amount      <= ev_end ? amount : '0;
				s1_s1.elapsed     <= ev_end ? elapsed : '0;
				s1_s1.mode        <= mode_n;
				s1_s1.weight      <= cur_w[ECHO_W-1:0];
			end
		end
	end

	// event bookkeeping, written on entry before any read
	always_ff @(posedge clk) begin
		if (accept && start_ev) begin
			before_q <= prev_q;
			start_q  <= time_ms;
		end
		if (accept && upd_last) begin
			last_q <= time_ms;
		end
	end

`ifndef SYNTH
	a_end_goes_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		s1_s1.valid && s1_s1.event_valid |-> s1_s1.mode == MODE_COOLDOWN)
		else $error("event end without cooldown");

	a_idle_never_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode_q == MODE_IDLE |=> mode_q != MODE_COOLDOWN)
		else $error("idle jumped straight to cooldown");

	a_mode_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(mode_q))
		else $error("mode moved without a transaction");

	a_event_from_event: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ev_end |-> mode_q == MODE_EVENT)
		else $error("event ended outside event mode");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		s1_s1.valid && !s1_s1.event_valid |-> s1_s1.amount == '0 && s1_s1.elapsed == '0)
		else $error("amount or duration set without an event end");
`endif

endmodule

FILE: design/wced_div1000.sv
module wced_div1000 import wced_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stage_t               s1,
	output logic                 s2_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 event_valid,
	output logic [AMOUNT_W-1:0]  amount_consumed,
	output logic [DUR_W-1:0]     event_seconds,
	output logic [MODE_W-1:0]    mode,
	output logic signed [ECHO_W-1:0] current_weight
);

	logic                valid_s2;
	logic                event_s2;
	logic [AMOUNT_W-1:0] amount_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic [MODE_W-1:0]   mode_s2;
	logic [ECHO_W-1:0]   weight_s2;

	// output register takes a new transaction when empty or being drained
	assign s2_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= s1.valid;
		end
	end

	// reciprocal multiply for the seconds count
	always_ff @(posedge clk) begin
		if (s2_ready && s1.valid) begin
			event_s2  <= s1.event_valid;
			amount_s2 <= s1.amount;
			prod_s2   <= PROD_W'(s1.elapsed) * PROD_W'(DIV_MUL);
			mode_s2   <= s1.mode;
			weight_s2 <= s1.weight;
		end
	end

	// result ports
	assign out_valid       = valid_s2;
	assign event_valid     = event_s2;
	assign amount_consumed = amount_s2;
	assign event_seconds   = prod_s2[DIV_SHIFT+DUR_W-1:DIV_SHIFT];
	assign mode            = mode_s2;
	assign current_weight  = weight_s2;

endmodule

FILE: design/weight_change_event_detector.sv
// channel   direction  handshake              payload
// cfg       in         cfg_we                 cfg_index, cfg_wdata
// sample    in         in_valid / in_ready    weight_sample, time_ms
// result    out        out_valid / out_ready  event_valid, amount_consumed,
//                                             event_seconds, mode, current_weight
//
// One sample per clock while the result side drains; after acceptance its result
// passes the mode update stage, then the divide-by-1000 multiply into the output register.
// Mode, previous weight and event times update in the acceptance cycle, so samples
// may follow back to back. A stalled result holds in the output register; one more
// sample is still taken into stage one before in_ready drops.
// Reset clears mode to idle, previous weight to zero and restores register defaults.
module weight_change_event_detector import wced_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [WEIGHT_WIDTH-1:0] weight_sample,
	input  logic [TIME_W-1:0]             time_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          event_valid,
	output logic [AMOUNT_W-1:0]           amount_consumed,
	output logic [DUR_W-1:0]              event_seconds,
	output logic [MODE_W-1:0]             mode,
	output logic signed [ECHO_W-1:0]      current_weight
);

	stage_t s1;
	logic   s2_ready;

	// mode tracking and event bookkeeping
	wced_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.weight_sample (weight_sample),
		.time_ms       (time_ms),
		.s2_ready      (s2_ready),
		.s1            (s1)
	);

	// duration in seconds and output register
	wced_div1000 u_div (
		.clk             (clk),
		.arst_n          (arst_n),
		.s1              (s1),
		.s2_ready        (s2_ready),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_valid     (event_valid),
		.amount_consumed (amount_consumed),
		.event_seconds   (event_seconds),
		.mode            (mode),
		.current_weight  (current_weight)
	);

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import wced_pkg::*;

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE     = 2'd0,
		MODE_EVENT    = 2'd1,
		MODE_COOLDOWN = 2'd2
	} detector_mode_t;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int WEIGHT_MIN = -8388608;
	localparam int WEIGHT_MAX = 8388607;

	typedef struct packed {
		logic                event_valid;
		logic [AMOUNT_W-1:0] amount;
		logic [DUR_W-1:0]    seconds;
		logic [MODE_W-1:0]   mode;
		logic [ECHO_W-1:0]   weight;
	} event_report_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]           cfg_index = '0;
	logic [CFG_DATA_W-1:0]          cfg_wdata = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic signed [WEIGHT_WIDTH-1:0] weight_sample = '0;
	logic [TIME_W-1:0]              time_ms = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           event_valid;
	logic [AMOUNT_W-1:0]            amount_consumed;
	logic [DUR_W-1:0]               event_seconds;
	logic [MODE_W-1:0]              mode;
	logic signed [ECHO_W-1:0]       current_weight;

	// detector copy: registers and state
	logic [THR_W-1:0]  model_thr = THRESHOLD_RST;
	logic [TIME_W-1:0] model_timeout = TIMEOUT_RST;
	logic [TIME_W-1:0] model_cooldown = COOLDOWN_RST;
	detector_mode_t    det_mode = MODE_IDLE;
	int                last_weight = 0;
	int                start_weight = 0;
	logic [TIME_W-1:0] start_stamp = '0;
	logic [TIME_W-1:0] change_stamp = '0;

	event_report_t pending_results[$];
	int            mismatch_count = 0;
	bit            steady_send = 1'b0;
	bit            steady_recv = 1'b0;

	weight_change_event_detector dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.weight_sample   (weight_sample),
		.time_ms         (time_ms),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_valid     (event_valid),
		.amount_consumed (amount_consumed),
		.event_seconds   (event_seconds),
		.mode            (mode),
		.current_weight  (current_weight)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("FAIL weight_change_event_detector");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// advance the detector copy by one sample and return its report
	function automatic event_report_t predict_sample(input int w, input logic [TIME_W-1:0] now);
		event_report_t     r;
		longint            diff;
		longint            mag;
		longint            amt;
		logic [TIME_W-1:0] span;
		r = '0;
		diff = longint'(w) - longint'(last_weight);
		mag = (diff < 0) ? -diff : diff;
		case (det_mode)
			MODE_EVENT: begin
				if (mag < longint'(model_thr)) begin
					span = now - change_stamp;
					if (span > model_timeout) begin
						amt = longint'(start_weight) - longint'(w);
						if (amt < 0)
							amt = 0;
						if (amt > longint'(AMOUNT_MAX))
							amt = longint'(AMOUNT_MAX);
						span = now - start_stamp;
						r.event_valid = 1'b1;
						r.amount = amt[AMOUNT_W-1:0];
						r.seconds = DUR_W'(span / 32'd1000);
						det_mode = MODE_COOLDOWN;
						change_stamp = now;
					end
				end else begin
					change_stamp = now;
				end
			end
			MODE_COOLDOWN: begin
				span = now - change_stamp;
				if (span > model_cooldown)
					det_mode = MODE_IDLE;
			end
			default: begin
				det_mode = MODE_IDLE;
				if (mag > longint'(model_thr)) begin
					det_mode = MODE_EVENT;
					start_weight = last_weight;
					start_stamp = now;
					change_stamp = now;
				end
			end
		endcase
		last_weight = w;
		r.mode = det_mode;
		r.weight = w[ECHO_W-1:0];
		return r;
	endfunction

	// one sample transaction, after a random gap unless steady sending is on
	task automatic send_sample(input int w, input logic [TIME_W-1:0] t);
		int gap;
		gap = steady_send ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		weight_sample <= w[WEIGHT_WIDTH-1:0];
		time_ms <= t;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_sample(w, t));
	endtask

	// hold the sender until every result is back and the pipe is empty
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_THRESHOLD: model_thr = data[THR_W-1:0];
			REG_TIMEOUT:   model_timeout = data;
			REG_COOLDOWN:  model_cooldown = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// result side: random stall before each transaction unless steady receiving is on
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady_recv ? 0 : $urandom_range(0, 16);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		event_report_t got;
		event_report_t want;
		if (out_valid && out_ready) begin
			got = {event_valid, amount_consumed, event_seconds, mode, current_weight};
			if (pending_results.size() == 0) begin
				report_mismatch("result with no sample outstanding");
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					report_mismatch({
						$sformatf("got ev %0b amt %0d sec %0d mode %0d w %0d, ",
							got.event_valid, got.amount, got.seconds, got.mode,
							$signed(got.weight)),
						$sformatf("want ev %0b amt %0d sec %0d mode %0d w %0d",
							want.event_valid, want.amount, want.seconds, want.mode,
							$signed(want.weight))});
			end
		end
	end

	// reset values: exact thresholds, clamped amount, timeout and cooldown edges
	task automatic test_default_sequence();
		send_sample(0, 32'd1000);
		send_sample(500, 32'd1100);
		send_sample(1001, 32'd1200);
		send_sample(1501, 32'd2000);
		send_sample(1400, 32'd32000);
		send_sample(1400, 32'd32001);
		send_sample(1400, 32'd37001);
		send_sample(1400, 32'd37002);
	endtask

	// widest threshold via masked write, zero timeouts, saturated amount, time wrap
	task automatic test_register_extremes();
		wait_idle();
		write_reg(REG_SPARE, 32'h0000_0001);
		write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
		write_reg(REG_TIMEOUT, 32'd0);
		write_reg(REG_COOLDOWN, 32'd0);
		send_sample(WEIGHT_MAX, 32'hFFFF_F000);
		send_sample(WEIGHT_MIN, 32'hFFFF_FFFF);
		send_sample(WEIGHT_MIN, 32'h0000_FFFF);
		send_sample(WEIGHT_MIN, 32'h0000_FFFF);
		send_sample(WEIGHT_MIN, 32'h0001_0000);
	endtask

	// longest duration, cooldown that cannot expire, zero threshold
	task automatic test_long_event();
		wait_idle();
		write_reg(REG_THRESHOLD, 32'd10);
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFE);
		write_reg(REG_COOLDOWN, 32'hFFFF_FFFF);
		send_sample(0, 32'd1);
		send_sample(0, 32'd0);
		send_sample(5, 32'hFFFF_FFFF);
		wait_idle();
		write_reg(REG_COOLDOWN, 32'd0);
		write_reg(REG_THRESHOLD, 32'd0);
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		send_sample(5, 32'd7);
		send_sample(6, 32'd8);
		send_sample(6, 32'd9);
	endtask

	// random settings per phase, mostly well-formed event sequences
	task automatic test_random_events();
		int                phase;
		int                n;
		int                pick;
		int                delta;
		int                w;
		int                span;
		int                hold_at;
		logic [23:0]       raw;
		logic [TIME_W-1:0] stamp;
		stamp = $urandom;
		for (phase = 0; phase < 8; phase++) begin
			wait_idle();
			write_reg(REG_THRESHOLD, ($urandom_range(0, 9) < 7) ?
				$urandom_range(1, 3000) : $urandom_range(0, WEIGHT_MAX));
			write_reg(REG_TIMEOUT, ($urandom_range(0, 9) < 8) ?
				$urandom_range(0, 5000) : $urandom);
			write_reg(REG_COOLDOWN, ($urandom_range(0, 9) < 8) ?
				$urandom_range(0, 5000) : $urandom);
			span = 200 + ((model_timeout < 3000) ? int'(model_timeout) : 3000);
			steady_send = ($urandom_range(0, 3) == 0);
			steady_recv = ($urandom_range(0, 3) == 0);
			hold_at = $urandom_range(20, 150);
			for (n = 0; n < 175; n++) begin
				if (n == hold_at)
					wait_idle();
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					// noise: any weight at any time
					raw = 24'($urandom);
					w = $signed(raw);
					stamp = $urandom;
				end else begin
					// time step, sometimes right on a timeout edge
					pick = $urandom_range(0, 99);
					if (pick < 12 && det_mode == MODE_EVENT)
						stamp = change_stamp + model_timeout + $urandom_range(0, 1);
					else if (pick < 24 && det_mode == MODE_COOLDOWN)
						stamp = change_stamp + model_cooldown + $urandom_range(0, 1);
					else if (pick < 28)
						stamp = stamp + $urandom;
					else
						stamp = stamp + $urandom_range(0, span);
					// weight step: near the threshold, large, or quiet drift
					pick = $urandom_range(0, 99);
					if (pick < 25)
						delta = int'(model_thr) + int'($urandom_range(0, 2)) - 1;
					else if (pick < 35)
						delta = $urandom_range(0, WEIGHT_MAX);
					else
						delta = $urandom_range(0, model_thr / 2);
					if ($urandom_range(0, 1) == 1)
						delta = -delta;
					w = last_weight + delta;
					if (w > WEIGHT_MAX)
						w = WEIGHT_MAX;
					if (w < WEIGHT_MIN)
						w = WEIGHT_MIN;
				end
				send_sample(w, stamp);
			end
		end
		steady_send = 1'b0;
		steady_recv = 1'b0;
	endtask

	// sequence of tests
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_default_sequence();
		test_register_extremes();
		test_long_event();
		test_random_events();
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS weight_change_event_detector");
		else
			$display("FAIL weight_change_event_detector");
		$finish;
	end

endmodule
